>>> src/sbl_pkg.sv
`default_nettype none

package sbl_pkg;

    // Operation selector carried on s_tuser.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted input beat
        logic exec;   // run the operation and load the result register
    } sbl_cmd_t;

endpackage

`default_nettype wire

>>> src/sbl_ctrl.sv
`default_nettype none

module sbl_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output sbl_pkg::sbl_cmd_t    cmd
);

    localparam logic IDLE_S = 1'b0;
    localparam logic EXEC_S = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    // The result register can take a new result when it is empty or drains now.
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            IDLE_S: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = EXEC_S;
                end
            end
            EXEC_S: begin
                if (slot_free) begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE_S;
                end
            end
            default: begin
                state_next = IDLE_S;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE_S;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == IDLE_S);
    assign m_tvalid = out_valid_reg;

    ap_exec_in_exec_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> state_reg == EXEC_S)
        else $error("exec issued outside the execute state");

    ap_load_then_exec_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == EXEC_S && !s_tready)
        else $error("accepted beat did not move the controller to execute");

    ap_exec_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid)
        else $error("result not presented after execution");

endmodule

`default_nettype wire

>>> src/sbl_datapath.sv
`default_nettype none

module sbl_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sbl_pkg::sbl_cmd_t             cmd,
    input  wire logic                          in_mode,
    input  wire logic [sbl_pkg::VALUE_W-1:0]   in_value,
    output logic [sbl_pkg::STATUS_W-1:0]       res_status,
    output logic [sbl_pkg::COUNT_W-1:0]        res_count,
    output logic                               res_empty
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [sbl_pkg::VALUE_W-1:0] entry_reg  [CAPACITY];
    logic [sbl_pkg::VALUE_W-1:0] entry_next [CAPACITY];
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        mode_reg;
    logic [sbl_pkg::VALUE_W-1:0] value_reg;
    logic [sbl_pkg::STATUS_W-1:0] status_reg;
    logic [sbl_pkg::STATUS_W-1:0] status_next;
    logic [sbl_pkg::COUNT_W-1:0] res_count_reg;
    logic                        res_empty_reg;

    logic [CAPACITY-1:0] gt;   // stored value smaller than the operand
    logic [CAPACITY-1:0] ge;   // stored value not smaller than the operand
    logic [CAPACITY-1:0] eq;
    logic                found;
    logic                full;
    logic                empty;
    logic                write_en;

    // Each cell compares against the operand and picks its neighbor in parallel.
    // The table is sorted, so gt is a prefix and the first equal cell is the
    // first cell with ge set.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                        occupied;
        logic [sbl_pkg::VALUE_W-1:0] ins_val;
        logic [sbl_pkg::VALUE_W-1:0] del_val;
        assign occupied = CW'(i) < count_reg;
        assign gt[i]    = occupied && (entry_reg[i] <  value_reg);
        assign ge[i]    = occupied && (entry_reg[i] >= value_reg);
        assign eq[i]    = occupied && (entry_reg[i] == value_reg);

        if (i == 0) begin : g_first
            assign ins_val = gt[i] ? entry_reg[i] : value_reg;
        end else begin : g_rest
            assign ins_val = gt[i]     ? entry_reg[i] :
                             gt[i - 1] ? value_reg    : entry_reg[i - 1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign del_val = entry_reg[i];
        end else begin : g_inner
            assign del_val = ge[i] ? entry_reg[i + 1] : entry_reg[i];
        end
        assign entry_next[i] = (mode_reg == sbl_pkg::MODE_INSERT) ? ins_val : del_val;
    end

    always_ff @(posedge aclk) begin
        if (write_en) begin
            entry_reg <= entry_next;
        end
    end

    assign found = |eq;
    assign full  = count_reg >= CW'(CAPACITY);
    assign empty = count_reg == '0;

    always_comb begin
        count_next = count_reg;
        write_en   = 1'b0;
        if (mode_reg == sbl_pkg::MODE_INSERT) begin
            if (full) begin
                status_next = sbl_pkg::ST_FULL;
            end else begin
                status_next = sbl_pkg::ST_INSERTED;
                count_next  = count_reg + 1'b1;
                write_en    = cmd.exec;
            end
        end else if (empty) begin
            status_next = sbl_pkg::ST_EMPTY;
        end else if (!found) begin
            status_next = sbl_pkg::ST_NOT_FOUND;
        end else begin
            status_next = sbl_pkg::ST_REMOVED;
            count_next  = count_reg - 1'b1;
            write_en    = cmd.exec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            value_reg <= in_value;
        end
        if (cmd.exec) begin
            status_reg    <= status_next;
            res_count_reg <= sbl_pkg::COUNT_W'(count_next);
            res_empty_reg <= (count_next == '0);
        end
    end

    assign res_status = status_reg;
    assign res_count  = res_count_reg;
    assign res_empty  = res_empty_reg;

    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    ap_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && status_next == sbl_pkg::ST_INSERTED
        |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("insert did not add one entry");

    ap_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && status_next == sbl_pkg::ST_REMOVED
        |=> count_reg == CW'($past(count_reg) - 1'b1))
        else $error("delete did not drop one entry");

    ap_reject_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && !write_en |=> $stable(count_reg))
        else $error("rejected operation changed the entry count");

endmodule

`default_nettype wire

>>> src/sorted_byte_list.sv
// Channel  Direction  Beat contents
// s_       in         tdata[7:0] value; tuser[0] mode (0 insert, 1 delete)
// m_       out        tdata[2:0] status, [7:3] entry_count, [8] list_empty
//
// Each operation accepts the beat, then runs an execute step in which
// every table cell compares against the value and shifts in parallel.
// The next beat is accepted while the previous result waits in the output register.
// A stalled m_ side holds the execute cycle until the output register frees.
// aresetn is synchronous and active low; it empties the table at once.
`default_nettype none

module sorted_byte_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] value
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [2:0] status, [7:3] entry_count, [8] list_empty
);

    sbl_pkg::sbl_cmd_t                 cmd;
    logic [sbl_pkg::STATUS_W-1:0]      res_status;
    logic [sbl_pkg::COUNT_W-1:0]       res_count;
    logic                              res_empty;

    sbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sbl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_mode    (s_tuser[0]),
        .in_value   (s_tdata),
        .res_status (res_status),
        .res_count  (res_count),
        .res_empty  (res_empty)
    );

    assign m_tdata = {7'd0, res_empty, res_count, res_status};

endmodule

`default_nettype wire

>>> dv/tb_sorted_byte_list.sv
`timescale 1ns / 1ps

module tb_sorted_byte_list;

    localparam int CAP         = 16;
    localparam int RANDOM_OPS  = 1700;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic       mode;
        logic [7:0] value;
    } table_op_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] count;
        logic       empty;
    } table_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    sorted_byte_list #(
        .CAPACITY(CAP)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted contents of the table, kept in ascending order.
    logic [7:0]    sorted_vals [CAP];
    int            held_count = 0;
    table_result_t expected_results [$];

    // The stimulus side tracks what will be stored, as a histogram, so that
    // deletes can aim at values that are present.
    table_op_t     pending_ops [$];
    int            gen_hist [256];
    int            gen_total = 0;

    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    int src_gap      = 0;
    int sink_wait    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int beats_out    = 0;
    int status_seen [5];

    function automatic table_result_t apply_table_op(input logic mode, input logic [7:0] v);
        int            pos;
        int            i;
        table_result_t r;
        pos = 0;
        if (mode == sbl_pkg::MODE_INSERT) begin
            if (held_count >= CAP) begin
                r.status = sbl_pkg::ST_FULL;
            end else begin
                while (pos < held_count && v > sorted_vals[pos])
                    pos++;
                for (i = held_count; i > pos; i--)
                    sorted_vals[i] = sorted_vals[i - 1];
                sorted_vals[pos] = v;
                held_count++;
                r.status = sbl_pkg::ST_INSERTED;
            end
        end else if (held_count == 0) begin
            r.status = sbl_pkg::ST_EMPTY;
        end else begin
            while (pos < held_count && sorted_vals[pos] != v)
                pos++;
            if (pos >= held_count) begin
                r.status = sbl_pkg::ST_NOT_FOUND;
            end else begin
                for (i = pos; i + 1 < held_count; i++)
                    sorted_vals[i] = sorted_vals[i + 1];
                held_count--;
                r.status = sbl_pkg::ST_REMOVED;
            end
        end
        r.count = held_count[4:0];
        r.empty = (held_count == 0);
        return r;
    endfunction

    function automatic void queue_op(input logic mode, input logic [7:0] v);
        table_op_t op;
        op.mode  = mode;
        op.value = v;
        pending_ops.push_back(op);
        if (mode == sbl_pkg::MODE_INSERT) begin
            if (gen_total < CAP) begin
                gen_hist[v]++;
                gen_total++;
            end
        end else if (gen_hist[v] > 0) begin
            gen_hist[v]--;
            gen_total--;
        end
    endfunction

    function automatic logic [7:0] pick_stored_value();
        int k;
        int v;
        k = $urandom_range(0, gen_total - 1);
        for (v = 0; v < 256; v++) begin
            if (k < gen_hist[v])
                return v[7:0];
            k -= gen_hist[v];
        end
        return 8'd0;
    endfunction

    // Mix of uniform bytes, edge values and a narrow range that breeds duplicates.
    function automatic logic [7:0] draw_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return 8'd127;
                    default: return 8'd128;
                endcase
            end
            1: return 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, 5) : 0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in %s at result %0d: got %0d, expected %0d", what, beats_out, got,
                 want);
        mismatches++;
    endtask

    // Driver: one beat per pending op, with a random gap after each when source idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_table_op(s_tuser[0], s_tdata));
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    table_op_t op;
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= op.value;
                    s_tuser  <= op.mode;
                    src_gap  <= draw_gap(src_idle_on);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and stalls m_tready at random.
    always @(posedge aclk) begin : result_side
        int            d;
        table_result_t want;
        if (aresetn) begin
            d = sink_wait;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch("status", m_tdata[2:0], want.status);
                    if (m_tdata[7:3] !== want.count)
                        report_mismatch("entry_count", m_tdata[7:3], want.count);
                    if (m_tdata[8] !== want.empty)
                        report_mismatch("list_empty", m_tdata[8], want.empty);
                end
                if (m_tdata[2:0] <= sbl_pkg::ST_FULL)
                    status_seen[m_tdata[2:0]]++;
                beats_out++;
                d = draw_gap(sink_idle_on);
            end
            if (d != 0) begin
                m_tready  <= 1'b0;
                sink_wait <= d - 1;
            end else begin
                m_tready  <= 1'b1;
                sink_wait <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] fill_vals [14];
        int         issued;
        int         burst_len;
        int         ins_pct;
        int         n;
        fill_vals = '{8'd128, 8'd1, 8'd254, 8'h55, 8'hAA, 8'd7, 8'd7,
                      8'd200, 8'd16, 8'd32, 8'd64, 8'd127, 8'd3, 8'd250};
        for (n = 0; n < 256; n++)
            gen_hist[n] = 0;
        for (n = 0; n < 5; n++)
            status_seen[n] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: delete on an empty table, extremes, duplicates, fill to
        // capacity, insert when full, delete of zero and of an absent value.
        queue_op(sbl_pkg::MODE_DELETE, 8'd0);
        queue_op(sbl_pkg::MODE_INSERT, 8'd255);
        queue_op(sbl_pkg::MODE_INSERT, 8'd0);
        queue_op(sbl_pkg::MODE_INSERT, 8'd0);
        queue_op(sbl_pkg::MODE_DELETE, 8'd128);
        queue_op(sbl_pkg::MODE_DELETE, 8'd0);
        for (n = 0; n < 14; n++)
            queue_op(sbl_pkg::MODE_INSERT, fill_vals[n]);
        queue_op(sbl_pkg::MODE_INSERT, 8'd9);
        queue_op(sbl_pkg::MODE_DELETE, 8'd0);
        queue_op(sbl_pkg::MODE_INSERT, 8'd0);
        queue_op(sbl_pkg::MODE_DELETE, 8'd100);

        // Hold off until the directed results have all drained.
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);

        // Random bursts that lean toward filling, draining or churning.
        issued = 0;
        while (issued < RANDOM_OPS) begin
            burst_len    = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0: ins_pct = 85;
                1: ins_pct = 15;
                2: ins_pct = 50;
                default: ins_pct = 60;
            endcase
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < burst_len; n++) begin
                if ($urandom_range(0, 99) < ins_pct)
                    queue_op(sbl_pkg::MODE_INSERT, draw_value());
                else if (gen_total > 0 && $urandom_range(0, 3) != 0)
                    queue_op(sbl_pkg::MODE_DELETE, pick_stored_value());
                else
                    queue_op(sbl_pkg::MODE_DELETE, draw_value());
            end
            issued += burst_len;
            while (pending_ops.size() > 8)
                @(negedge aclk);
        end

        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d results: %0d inserted, %0d removed, %0d not found,", beats_out,
                 status_seen[sbl_pkg::ST_INSERTED], status_seen[sbl_pkg::ST_REMOVED],
                 status_seen[sbl_pkg::ST_NOT_FOUND]);
        $display("%0d deletes on an empty table, %0d inserts rejected as full.",
                 status_seen[sbl_pkg::ST_EMPTY], status_seen[sbl_pkg::ST_FULL]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
src/sbl_pkg.sv
src/sbl_ctrl.sv
src/sbl_datapath.sv
src/sorted_byte_list.sv
dv/tb_sorted_byte_list.sv
